// ===== rtl/sfr_pkg.sv =====
// shared constants and types for the stream find-and-replace block
`timescale 1ns / 1ps

package sfr_pkg;

  // default sizes of the search and replacement buffers
  localparam int unsigned MAX_FIND_BYTES_DEF    = 8;
  localparam int unsigned MAX_REPLACE_BYTES_DEF = 8;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIND_PATTERN   = 3'd0,
    CFG_FIND_LENGTH    = 3'd1,
    CFG_REPLACE_TEXT   = 3'd2,
    CFG_REPLACE_LENGTH = 3'd3
  } cfg_reg_e;

  // one result item waiting in the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } sfr_entry_t;

  // window cell controls
  typedef struct packed {
    logic write;
    logic shift;
  } sfr_win_ctrl_t;

  // output queue cell controls
  typedef struct packed {
    logic pop;
    logic ld_lo;
    logic ld_hi;
  } sfr_q_ctrl_t;

endpackage

// ===== rtl/sfr_if.sv =====
// stream and configuration channel interfaces
`timescale 1ns / 1ps

// text input channel
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

// rewritten text output channel
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, out_byte, byte_valid, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, last, output ready);
endinterface

// register write channel
interface sfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sfr_pkg::CFG_IDX_W-1:0]  index;
  logic [sfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sfr_window_cell.sv =====
// one byte slot of the match window with its pattern compare
`timescale 1ns / 1ps

module sfr_window_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned FW  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfr_pkg::sfr_win_ctrl_t ctrl_i,
  input  logic [FW-1:0]         fill_i,
  input  logic [7:0]            in_byte_i,
  input  logic [7:0]            pat_byte_i,
  input  logic [7:0]            nbr_byte_i,
  output logic [7:0]            byte_o,
  output logic                  match_o
);

  logic [7:0] byte_q, byte_d;
  logic       here;

  // the incoming byte lands in the slot at the fill position
  assign here    = (fill_i == FW'(IDX));
  assign byte_o  = here ? in_byte_i : byte_q;
  assign match_o = (byte_o == pat_byte_i);

  // shift toward the head on a miss in a full window, else take the new byte
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = nbr_byte_i;
    end else if (ctrl_i.write && here) begin
      byte_d = in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== rtl/sfr_queue_cell.sv =====
// one slot of the output queue, shifting toward the head on a pop
`timescale 1ns / 1ps

module sfr_queue_cell (
  input  logic                clk_i,
  input  sfr_pkg::sfr_q_ctrl_t ctrl_i,
  input  sfr_pkg::sfr_entry_t  nbr_i,
  input  sfr_pkg::sfr_entry_t  lo_i,
  input  sfr_pkg::sfr_entry_t  hi_i,
  output sfr_pkg::sfr_entry_t  entry_o
);

  sfr_pkg::sfr_entry_t entry_q, entry_d;

  // load a new result or move up behind the popped head
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ld_lo) begin
      entry_d = lo_i;
    end else if (ctrl_i.ld_hi) begin
      entry_d = hi_i;
    end else if (ctrl_i.pop) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/stream_find_replace.sv =====
// top level of the streaming find-and-replace block
//
// Text enters on in_i one byte item per cycle while in_i.ready is high, with
// end_of_stream on the final byte. Rewritten text leaves on out_o;
// byte_valid low marks the empty end item sent when the last window matched
// an empty replacement, and last flags the final result of the stream.
// Registers must be written on cfg_i only while no item is in flight; the
// block does not enforce this. Writing find_length empties the match window.
// One byte per cycle is taken while each item yields at most one result and
// out_o does not stall. An item that yields n results (a replacement or the
// flush at end of stream) takes n queue slots, and in_i takes no new item
// while more than one result is queued. The window cells compare the whole
// window in the cycle the byte arrives; the output queue drains one result
// per cycle while out_o is ready. When out_o stalls, one result may wait
// while another item is taken. Reset empties the window and queue and loads
// the register defaults: all-zero pattern of length 1, empty replacement.
`timescale 1ns / 1ps

module stream_find_replace #(
  parameter int unsigned MAX_FIND_BYTES    = sfr_pkg::MAX_FIND_BYTES_DEF,
  parameter int unsigned MAX_REPLACE_BYTES = sfr_pkg::MAX_REPLACE_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfr_in_if.sink           in_i,
  sfr_out_if.source        out_o,
  sfr_cfg_if.sink          cfg_i
);

  localparam int unsigned MAXR = (MAX_FIND_BYTES > MAX_REPLACE_BYTES) ?
                                 MAX_FIND_BYTES : MAX_REPLACE_BYTES;
  localparam int unsigned QD   = MAXR + 1;
  localparam int unsigned FW   = $clog2(MAX_FIND_BYTES + 1);
  localparam int unsigned RW   = $clog2(MAX_REPLACE_BYTES + 1);
  localparam int unsigned NW   = $clog2(MAXR + 1);
  localparam int unsigned CW   = $clog2(QD + 1);

  // configuration registers
  logic [63:0] find_pat_q;
  logic [3:0]  find_len_q;
  logic [63:0] repl_txt_q;
  logic [3:0]  repl_len_q;
  logic        cfg_wr;
  logic        len_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;
  assign len_wr      = cfg_wr && (cfg_i.index == sfr_pkg::CFG_FIND_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_pat_q <= '0;
      find_len_q <= 4'd1;
      repl_txt_q <= '0;
      repl_len_q <= 4'd0;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        sfr_pkg::CFG_FIND_PATTERN:   find_pat_q <= cfg_i.data;
        sfr_pkg::CFG_FIND_LENGTH:    find_len_q <= cfg_i.data[3:0];
        sfr_pkg::CFG_REPLACE_TEXT:   repl_txt_q <= cfg_i.data;
        sfr_pkg::CFG_REPLACE_LENGTH: repl_len_q <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // clamp lengths into the supported range
  logic [FW-1:0] len_eff;
  logic [RW-1:0] rlen_eff;

  always_comb begin
    if (find_len_q == 4'd0) begin
      len_eff = FW'(1);
    end else if (find_len_q > 4'(MAX_FIND_BYTES)) begin
      len_eff = FW'(MAX_FIND_BYTES);
    end else begin
      len_eff = find_len_q[FW-1:0];
    end
    if (repl_len_q > 4'(MAX_REPLACE_BYTES)) begin
      rlen_eff = RW'(MAX_REPLACE_BYTES);
    end else begin
      rlen_eff = repl_len_q[RW-1:0];
    end
  end

  // handshakes
  logic [CW-1:0] cnt_q, cnt_d;
  logic          acc;
  logic          pop;
  logic          eos;

  assign in_i.ready = (cnt_q <= CW'(1));
  assign acc        = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;
  assign eos        = in_i.end_of_stream;

  // match window: a row of cells
  logic [FW-1:0]          fill_q, fill_d;
  logic [FW-1:0]          fill_p1;
  logic                   full;
  logic                   hit;
  logic [7:0]             wnew [MAX_FIND_BYTES];
  logic [MAX_FIND_BYTES-1:0] match_v;
  logic [MAX_FIND_BYTES-1:0] hit_v;
  sfr_pkg::sfr_win_ctrl_t win_ctrl;

  assign fill_p1        = fill_q + FW'(1);
  assign full           = (fill_p1 == len_eff);
  assign hit            = &hit_v;
  assign win_ctrl.write = acc;
  assign win_ctrl.shift = acc && full && !hit && !eos;

  for (genvar k = 0; k < MAX_FIND_BYTES; k++) begin : g_win
    logic [7:0] nbr;
    if (k < MAX_FIND_BYTES - 1) begin : g_mid
      assign nbr = wnew[k+1];
    end else begin : g_end
      assign nbr = 8'd0;
    end

    sfr_window_cell #(
      .IDX (k),
      .FW  (FW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (win_ctrl),
      .fill_i     (fill_q),
      .in_byte_i  (in_i.in_byte),
      .pat_byte_i (find_pat_q[8*k +: 8]),
      .nbr_byte_i (nbr),
      .byte_o     (wnew[k]),
      .match_o    (match_v[k])
    );

    // slots past the pattern length do not take part
    assign hit_v[k] = match_v[k] || (FW'(k) >= len_eff);
  end

  // window fill count
  always_comb begin
    fill_d = fill_q;
    if (len_wr) begin
      fill_d = '0;
    end else if (acc) begin
      if (eos || (full && hit)) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = fill_q;
      end else begin
        fill_d = fill_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // results of the item: window bytes, replacement or empty end item
  logic          sel_repl;
  logic          marker;
  logic [NW-1:0] n_res;

  assign sel_repl = full && hit;
  assign marker   = sel_repl && eos && (rlen_eff == '0);

  always_comb begin
    if (!full) begin
      n_res = eos ? NW'(fill_p1) : '0;
    end else if (hit) begin
      n_res = marker ? NW'(1) : NW'(rlen_eff);
    end else begin
      n_res = eos ? NW'(len_eff) : NW'(1);
    end
  end

  sfr_pkg::sfr_entry_t res [MAXR];

  for (genvar j = 0; j < MAXR; j++) begin : g_res
    logic [7:0] wb;
    logic [7:0] rb;
    if (j < MAX_FIND_BYTES) begin : g_wb
      assign wb = wnew[j];
    end else begin : g_wz
      assign wb = 8'd0;
    end
    if (j < MAX_REPLACE_BYTES) begin : g_rb
      assign rb = repl_txt_q[8*j +: 8];
    end else begin : g_rz
      assign rb = 8'd0;
    end
    assign res[j].data       = marker ? 8'd0 : (sel_repl ? rb : wb);
    assign res[j].byte_valid = !marker;
    assign res[j].last       = eos && (n_res == NW'(j + 1));
  end

  // output queue: a row of cells drained from the head
  logic                base;
  sfr_pkg::sfr_entry_t qe [QD];

  assign base = (cnt_q == CW'(1)) && !pop;

  for (genvar k = 0; k < QD; k++) begin : g_q
    sfr_pkg::sfr_entry_t nbr;
    sfr_pkg::sfr_entry_t lo;
    sfr_pkg::sfr_entry_t hi;
    sfr_pkg::sfr_q_ctrl_t qc;

    if (k < QD - 1) begin : g_nbr
      assign nbr = qe[k+1];
      assign lo  = res[k];
    end else begin : g_nbr_end
      assign nbr = '0;
      assign lo  = '0;
    end
    if (k >= 1) begin : g_hi
      assign hi       = res[k-1];
      assign qc.ld_hi = acc && base && (CW'(k - 1) < CW'(n_res));
    end else begin : g_hi_none
      assign hi       = '0;
      assign qc.ld_hi = 1'b0;
    end
    assign qc.pop   = pop;
    assign qc.ld_lo = acc && !base && (CW'(k) < CW'(n_res));

    sfr_queue_cell u_qcell (
      .clk_i   (clk_i),
      .ctrl_i  (qc),
      .nbr_i   (nbr),
      .lo_i    (lo),
      .hi_i    (hi),
      .entry_o (qe[k])
    );
  end

  // queue occupancy
  assign cnt_d = cnt_q - CW'(pop) + (acc ? CW'(n_res) : CW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = qe[0].data;
  assign out_o.byte_valid = qe[0].byte_valid;
  assign out_o.last       = qe[0].last;

endmodule

// ===== rtl/sfr_checker.sv =====
// port-level checks for the stream find-and-replace block
`timescale 1ns / 1ps

module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_eos,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_bv,
  input logic       out_last
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_bv) && $stable(out_last))
    else $error("result changed while stalled");

  // the empty end item is always the last one
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_bv |-> out_last)
    else $error("empty item without last");

  // the empty end item carries a zero byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_bv |-> out_byte == 8'd0)
    else $error("empty item with nonzero byte");

  // the end of a stream always produces a result right away
  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_eos |=> out_valid)
    else $error("no result after end of stream");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_eos    (in_i.end_of_stream),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .out_bv    (out_o.byte_valid),
  .out_last  (out_o.last)
);
